>>> sv/tpm_pkg.sv
// Shared types, constants and codes for the touch point mapper.
package tpm_pkg;

    // Fixed field widths
    localparam int RAW_BITS      = 12;
    localparam int SCREEN_BITS   = 10;
    localparam int TIME_BITS     = 32;
    localparam int SIZE_BITS     = 11;
    localparam int ORIENT_BITS   = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;
    localparam int EVENT_BITS    = 3;

    // Divider operand widths: |raw - low| * top fits in DIV_BITS
    localparam int DIV_BITS = RAW_BITS + SCREEN_BITS;
    localparam int DEN_BITS = RAW_BITS;

    // Largest screen size in pixels
    localparam int SCREEN_MAX = 1 << SCREEN_BITS;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RAW_X_LOW     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RAW_X_HIGH    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_RAW_Y_LOW     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_RAW_Y_HIGH    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIENTATION   = 3'd6;

    // Orientation bits
    localparam int ORIENT_SWAP  = 0;
    localparam int ORIENT_INV_X = 1;
    localparam int ORIENT_INV_Y = 2;

    // Event codes
    localparam logic [EVENT_BITS-1:0] EV_NONE      = 3'd0;
    localparam logic [EVENT_BITS-1:0] EV_TAB_VIB   = 3'd1;
    localparam logic [EVENT_BITS-1:0] EV_TAB_TEMP  = 3'd2;
    localparam logic [EVENT_BITS-1:0] EV_TAB_THERM = 3'd3;
    localparam logic [EVENT_BITS-1:0] EV_TAB_SOUND = 3'd4;
    localparam logic [EVENT_BITS-1:0] EV_TAB_SYS   = 3'd5;
    localparam logic [EVENT_BITS-1:0] EV_PAGE_PREV = 3'd6;
    localparam logic [EVENT_BITS-1:0] EV_PAGE_NEXT = 3'd7;

    // Zone geometry and tap hold-off
    localparam int TAP_HOLDOFF_MS = 250;
    localparam int TAB_BAND_Y     = 200;
    localparam int TAB_EDGE_1     = 64;
    localparam int TAB_EDGE_2     = 128;
    localparam int TAB_EDGE_3     = 192;
    localparam int TAB_EDGE_4     = 256;
    localparam int PAGE_PREV_X    = 30;
    localparam int PAGE_NEXT_X    = 290;

    // Reset values of the configuration registers
    localparam logic [SIZE_BITS-1:0]   RST_SCREEN_WIDTH  = 11'd320;
    localparam logic [SIZE_BITS-1:0]   RST_SCREEN_HEIGHT = 11'd240;
    localparam logic [RAW_BITS-1:0]    RST_RAW_LOW       = 12'd200;
    localparam logic [RAW_BITS-1:0]    RST_RAW_HIGH      = 12'd3900;
    localparam logic [ORIENT_BITS-1:0] RST_ORIENTATION   = 3'd0;

    // Input transaction payload
    typedef struct packed {
        logic                 touch_present;
        logic [RAW_BITS-1:0]  raw_x;
        logic [RAW_BITS-1:0]  raw_y;
        logic [TIME_BITS-1:0] now_ms;
    } t_in_item;

    // Output transaction payload
    typedef struct packed {
        logic [EVENT_BITS-1:0]  event_code;
        logic [SCREEN_BITS-1:0] screen_x;
        logic [SCREEN_BITS-1:0] screen_y;
        logic                   pressed;
    } t_out_item;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DSTART,
        ST_DWAIT,
        ST_POST,
        ST_DONE
    } t_state;

endpackage

>>> sv/tpm_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, unsigned magnitudes.
module tpm_div
    import tpm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIV_BITS-1:0] i_dividend,
    input  logic [DEN_BITS-1:0] i_divisor,
    output t_div_stat           o_stat,
    output logic [DIV_BITS-1:0] o_quotient
);

    localparam int CNT_BITS = $clog2(DIV_BITS + 1);

    logic [DIV_BITS-1:0] r_dvd, n_dvd;     // dividend bits out, quotient bits in
    logic [DEN_BITS-1:0] r_rem, n_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_busy, n_busy;

    logic [DEN_BITS:0]   rem_sh;
    logic [DEN_BITS+1:0] trial;

    // One restoring step
    always_comb begin
        rem_sh = {r_rem, r_dvd[DIV_BITS-1]};
        trial  = {1'b0, rem_sh} - {2'b00, r_den};
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_cnt  = CNT_BITS'(DIV_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!trial[DEN_BITS+1]) begin
                n_rem = trial[DEN_BITS-1:0];
                n_dvd = {r_dvd[DIV_BITS-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DEN_BITS-1:0];
                n_dvd = {r_dvd[DIV_BITS-2:0], 1'b0};
            end
            n_cnt  = r_cnt - CNT_BITS'(1);
            n_busy = (r_cnt != CNT_BITS'(1));
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_divisor;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && (r_cnt == CNT_BITS'(1));
    assign o_quotient  = r_dvd;

endmodule

>>> sv/touch_point_map_and_zone_event.sv
// Top level of the touch point mapper and zone event generator.
//
// Each accepted touch sample is mapped to screen pixels one axis at a time:
// a registered multiply forms |raw - low| * (size - 1), then one shared
// restoring divider produces one quotient bit per cycle, and a post step
// applies sign, inversion and clamp. Each axis passes through the multiply,
// divider start, divide wait and post step states in that order; a sample
// without touch skips the mapping and goes straight to the output. A new
// sample is accepted only once the previous one has left the sequencer. The
// result sits in an output register, so the next sample is accepted while it
// waits; a finished sample holds the block until that register is free. The
// configuration port is always ready; the user must write it only while
// idle, as the block itself does not enforce this.
module touch_point_map_and_zone_event
    import tpm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Input samples
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_item                 i_in_data,
    // Results
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_item                o_out_data,
    // Configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // Configuration registers
    logic [SIZE_BITS-1:0]   r_width, r_height;
    logic [RAW_BITS-1:0]    r_xlo, r_xhi, r_ylo, r_yhi;
    logic [ORIENT_BITS-1:0] r_orient;

    // Block state
    logic [TIME_BITS-1:0]   r_last;
    logic [SCREEN_BITS-1:0] r_stored_x, r_stored_y;

    // Sequencer and working registers
    t_state                 r_state, n_state;
    logic                   r_axis;
    t_in_item               r_item;
    logic [DIV_BITS-1:0]    r_num;
    logic [DEN_BITS-1:0]    r_den;
    logic                   r_neg;
    logic [SCREEN_BITS-1:0] r_map_x, r_map_y;
    logic                   r_out_valid;
    t_out_item              r_out_data;

    // Sequencer outputs
    logic accept, div_start, mul_load, post_load, commit, out_free;

    // Divider link
    t_div_stat           div_stat;
    logic [DIV_BITS-1:0] div_quot;

    // Effective screen tops (size minus one, size held to 1..SCREEN_MAX)
    logic [SCREEN_BITS-1:0] wtop, htop;

    always_comb begin
        if (r_width == '0) begin
            wtop = '0;
        end else if (32'(r_width) > SCREEN_MAX) begin
            wtop = SCREEN_BITS'(SCREEN_MAX - 1);
        end else begin
            wtop = SCREEN_BITS'(r_width - SIZE_BITS'(1));
        end
        if (r_height == '0) begin
            htop = '0;
        end else if (32'(r_height) > SCREEN_MAX) begin
            htop = SCREEN_BITS'(SCREEN_MAX - 1);
        end else begin
            htop = SCREEN_BITS'(r_height - SIZE_BITS'(1));
        end
    end

    // Operand selection for the axis in work; swap picks the other raw channel
    logic                   use_y;
    logic [RAW_BITS-1:0]    sel_raw, sel_lo, sel_hi;
    logic [SCREEN_BITS-1:0] sel_top;
    logic                   sel_inv;

    assign use_y   = r_axis ^ r_orient[ORIENT_SWAP];
    assign sel_raw = use_y ? r_item.raw_y : r_item.raw_x;
    assign sel_lo  = use_y ? r_ylo : r_xlo;
    assign sel_hi  = use_y ? r_yhi : r_xhi;
    assign sel_top = r_axis ? htop : wtop;
    assign sel_inv = r_axis ? r_orient[ORIENT_INV_Y] : r_orient[ORIENT_INV_X];

    // Magnitudes and signs of offset and span
    logic                    off_neg, span_neg;
    logic [RAW_BITS-1:0]     off_mag, span_mag;
    logic [DIV_BITS-1:0]     product;

    always_comb begin
        off_neg  = sel_raw < sel_lo;
        span_neg = sel_hi < sel_lo;
        off_mag  = off_neg ? (sel_lo - sel_raw) : (sel_raw - sel_lo);
        span_mag = span_neg ? (sel_lo - sel_hi) : (sel_hi - sel_lo);
        product  = DIV_BITS'(off_mag) * DIV_BITS'(sel_top);
    end

    // Post step: sign, inversion, clamp; zero span gives a zero quotient before inversion
    logic signed [DIV_BITS+1:0] q_signed, q_inv, top_s;
    logic [SCREEN_BITS-1:0]     post_val;

    always_comb begin
        top_s    = $signed({{(DIV_BITS+2-SCREEN_BITS){1'b0}}, sel_top});
        q_signed = $signed({2'b00, div_quot});
        if (r_den == '0) begin
            q_signed = '0;
        end else if (r_neg) begin
            q_signed = -q_signed;
        end
        q_inv = sel_inv ? (top_s - q_signed) : q_signed;
        if (q_inv < 0) begin
            post_val = '0;
        end else if (q_inv > top_s) begin
            post_val = sel_top;
        end else begin
            post_val = q_inv[SCREEN_BITS-1:0];
        end
    end

    // Tap hold-off and zone decode
    logic [TIME_BITS-1:0]  elapsed;
    logic                  tap_ok;
    logic [EVENT_BITS-1:0] zone_ev;

    always_comb begin
        elapsed = r_item.now_ms - r_last;
        tap_ok  = 32'(elapsed) >= TAP_HOLDOFF_MS;
        zone_ev = EV_NONE;
        if (32'(r_map_y) >= TAB_BAND_Y) begin
            if (32'(r_map_x) < TAB_EDGE_1) begin
                zone_ev = EV_TAB_VIB;
            end else if (32'(r_map_x) < TAB_EDGE_2) begin
                zone_ev = EV_TAB_TEMP;
            end else if (32'(r_map_x) < TAB_EDGE_3) begin
                zone_ev = EV_TAB_THERM;
            end else if (32'(r_map_x) < TAB_EDGE_4) begin
                zone_ev = EV_TAB_SOUND;
            end else begin
                zone_ev = EV_TAB_SYS;
            end
        end else if (32'(r_map_x) < PAGE_PREV_X) begin
            zone_ev = EV_PAGE_PREV;
        end else if (32'(r_map_x) > PAGE_NEXT_X) begin
            zone_ev = EV_PAGE_NEXT;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_in_data.touch_present ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL:    n_state = ST_DSTART;
            ST_DSTART: n_state = ST_DWAIT;
            ST_DWAIT: begin
                if (div_stat.done) begin
                    n_state = ST_POST;
                end
            end
            ST_POST:   n_state = r_axis ? ST_DONE : ST_MUL;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        div_start  = 1'b0;
        mul_load   = 1'b0;
        post_load  = 1'b0;
        commit     = 1'b0;
        case (r_state)
            ST_IDLE:   o_in_ready = 1'b1;
            ST_MUL:    mul_load   = 1'b1;
            ST_DSTART: div_start  = 1'b1;
            ST_DWAIT:  ;
            ST_POST:   post_load  = 1'b1;
            ST_DONE:   commit     = out_free;
            default:   ;
        endcase
    end

    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Shared divider
    tpm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_num),
        .i_divisor  (r_den),
        .o_stat     (div_stat),
        .o_quotient (div_quot)
    );

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_stored_x  <= '0;
            r_stored_y  <= '0;
            r_width     <= RST_SCREEN_WIDTH;
            r_height    <= RST_SCREEN_HEIGHT;
            r_xlo       <= RST_RAW_LOW;
            r_xhi       <= RST_RAW_HIGH;
            r_ylo       <= RST_RAW_LOW;
            r_yhi       <= RST_RAW_HIGH;
            r_orient    <= RST_ORIENTATION;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_axis <= 1'b0;
            end else if (post_load) begin
                r_axis <= 1'b1;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // Commit the sample to the block state
            if (commit) begin
                if (r_item.touch_present) begin
                    r_stored_x <= r_map_x;
                    r_stored_y <= r_map_y;
                    if (tap_ok) begin
                        r_last <= r_item.now_ms;
                    end
                end
            end
            // Register writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_SCREEN_WIDTH:  r_width  <= i_cfg_data[SIZE_BITS-1:0];
                    REG_SCREEN_HEIGHT: r_height <= i_cfg_data[SIZE_BITS-1:0];
                    REG_RAW_X_LOW:     r_xlo    <= i_cfg_data[RAW_BITS-1:0];
                    REG_RAW_X_HIGH:    r_xhi    <= i_cfg_data[RAW_BITS-1:0];
                    REG_RAW_Y_LOW:     r_ylo    <= i_cfg_data[RAW_BITS-1:0];
                    REG_RAW_Y_HIGH:    r_yhi    <= i_cfg_data[RAW_BITS-1:0];
                    REG_ORIENTATION:   r_orient <= i_cfg_data[ORIENT_BITS-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_data;
        end
        if (mul_load) begin
            r_num <= product;
            r_den <= span_mag;
            r_neg <= off_neg ^ span_neg;
        end
        if (post_load) begin
            if (r_axis) begin
                r_map_y <= post_val;
            end else begin
                r_map_x <= post_val;
            end
        end
        if (commit) begin
            r_out_data.pressed <= r_item.touch_present;
            if (r_item.touch_present) begin
                r_out_data.event_code <= tap_ok ? zone_ev : EV_NONE;
                r_out_data.screen_x   <= r_map_x;
                r_out_data.screen_y   <= r_map_y;
            end else begin
                r_out_data.event_code <= EV_NONE;
                r_out_data.screen_x   <= r_stored_x;
                r_out_data.screen_y   <= r_stored_y;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A divider start is always followed by a busy divider
    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DSTART) |=> div_stat.busy)
        else $error("divider did not start");

    // The divider only finishes while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == ST_DWAIT))
        else $error("divider finished outside the wait state");

    // No new sample is taken while the divider works
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> !o_in_ready)
        else $error("input ready while divider busy");

    // A new result is never loaded over one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("pending result overwritten");

    // An event is only reported for a touched sample
    a_event_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.event_code != EV_NONE)) |-> o_out_data.pressed)
        else $error("event without touch");

endmodule
